[src/rcmf_pkg.sv]
// ============================================================================
// rcmf_pkg
// Shared widths, types and register codes of the RGBA color matrix filter.
// ============================================================================
`default_nettype none

package rcmf_pkg;

  localparam int CHAN_W     = 8;                  // one color channel
  localparam int COEF_W     = 16;                 // signed Q3.12 coefficient
  localparam int NUM_CHAN   = 4;                  // r, g, b, a
  localparam int NUM_COLS   = 5;                  // r, g, b, a, offset
  localparam int NUM_GROUPS = 5;                  // packed coefficient registers
  localparam int REG_W      = 64;                 // register width
  localparam int ADDR_W     = 6;                  // byte address, 8 bytes a register
  localparam int REG_SEL_W  = 3;                  // register index in paddr
  localparam int PROD_W     = COEF_W + CHAN_W + 1; // coef times zero-extended channel
  localparam int ACC_W      = PROD_W + 3;          // sum of five products

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF; // offset column multiplier

  typedef logic [NUM_GROUPS-1:0][REG_W-1:0]   coef_bank_t;
  typedef logic [NUM_COLS-1:0][COEF_W-1:0]    coef_row_t;
  typedef logic [NUM_COLS-1:0][CHAN_W-1:0]    pix_col_t;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_COEF0 = 3'd0,
    REG_COEF1 = 3'd1,
    REG_COEF2 = 3'd2,
    REG_COEF3 = 3'd3,
    REG_COEF4 = 3'd4
  } reg_sel_t;

  // coefficient idx lives in register idx/4, lane idx%4
  function automatic logic [COEF_W-1:0] coef_at(coef_bank_t bank, logic [4:0] idx);
    logic [REG_W-1:0] grp;
    grp = bank[idx[4:2]];
    return grp[{idx[1:0], 4'b0000} +: COEF_W];
  endfunction

endpackage

`default_nettype wire

[src/rcmf_regs.sv]
// ============================================================================
// rcmf_regs
// APB register file holding the five packed coefficient registers.
// ============================================================================
`default_nettype none

module rcmf_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [rcmf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rcmf_pkg::REG_W-1:0]  pwdata,
  output      logic [rcmf_pkg::REG_W-1:0]  prdata,
  output      logic                      pready,
  output      rcmf_pkg::coef_bank_t      coef
);
  import rcmf_pkg::*;

  logic     wr_en;
  reg_sel_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_sel_t'(paddr[ADDR_W-1 -: REG_SEL_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr_en) begin
      unique case (sel)
        REG_COEF0: coef[0] <= pwdata;
        REG_COEF1: coef[1] <= pwdata;
        REG_COEF2: coef[2] <= pwdata;
        REG_COEF3: coef[3] <= pwdata;
        REG_COEF4: coef[4] <= pwdata;
        default: ;  // unmapped: dropped
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_COEF0: prdata = coef[0];
      REG_COEF1: prdata = coef[1];
      REG_COEF2: prdata = coef[2];
      REG_COEF3: prdata = coef[3];
      REG_COEF4: prdata = coef[4];
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/rcmf_row.sv]
// ============================================================================
// rcmf_row
// One matrix row: five products, two-level add, then clamp to 0..255.
// ============================================================================
`default_nettype none

module rcmf_row #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                         clk,
  input  wire rcmf_pkg::coef_row_t          coef,
  input  wire rcmf_pkg::pix_col_t           pix,
  output      logic [rcmf_pkg::CHAN_W-1:0]  chan
);
  import rcmf_pkg::*;

  logic signed [PROD_W-1:0] prod [NUM_COLS];
  logic signed [ACC_W-1:0]  sum_lo;
  logic signed [ACC_W-1:0]  sum_hi;
  logic signed [ACC_W-1:0]  sum_off;
  logic signed [ACC_W-1:0]  acc;
  logic [CHAN_W-1:0]        chan_next;

  // stage 1: products
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_COLS; c++) begin
      prod[c] <= $signed(coef[c]) * $signed({1'b0, pix[c]});
    end
  end

  // stage 2: pairwise sums
  always_ff @(posedge clk) begin
    sum_lo  <= ACC_W'(prod[0]) + ACC_W'(prod[1]);
    sum_hi  <= ACC_W'(prod[2]) + ACC_W'(prod[3]);
    sum_off <= ACC_W'(prod[4]);
  end

  // stage 3: full row sum
  always_ff @(posedge clk) begin
    acc <= sum_lo + sum_hi + sum_off;
  end

  // negative -> 0, whole part above 255 -> 255, else drop the fraction
  always_comb begin
    if (acc[ACC_W-1]) begin
      chan_next = '0;
    end else if (|acc[ACC_W-2:FRAC_BITS+CHAN_W]) begin
      chan_next = CHAN_MAX;
    end else begin
      chan_next = acc[FRAC_BITS +: CHAN_W];
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    chan <= chan_next;
  end

endmodule

`default_nettype wire

[src/rgba_color_matrix_filter.sv]
// ============================================================================
// rgba_color_matrix_filter
// 4x5 RGBA color matrix (feColorMatrix style) with Q3.12 coefficients.
// ============================================================================
// Usage:
//   Pixel in: drive in_red/in_green/in_blue/in_alpha and pulse start. A word
//   is taken at every clock edge with start high and busy low. busy is never
//   raised, so one pixel per clock is sustained indefinitely.
//   Pixel out: done is high for exactly one cycle with out_* valid. A pixel
//   moves from the accepting edge through the products, pair sums, row sum
//   and clamp, one register stage each, all four rows side by side. The
//   receiver cannot stall; results are not held.
//   Config: APB, five 64-bit coefficient registers at byte address 8*i.
//   Coefficient 4k+j sits in bits 16j+15..16j of register k, two's
//   complement with COEF_FRAC_BITS fraction bits. Writes to unmapped
//   addresses are dropped and read back as zero. Change coefficients only
//   while no pixel is in flight.
//   Reset (rst, synchronous): clears the coefficients (all outputs then 0)
//   and the in-flight valid bits; pixels already in the pipe are dropped.
// ============================================================================
`default_nettype none

module rgba_color_matrix_filter #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rcmf_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rcmf_pkg::REG_W-1:0]    pwdata,
  output      logic [rcmf_pkg::REG_W-1:0]    prdata,
  output      logic                          pready,
  // pixel in
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [rcmf_pkg::CHAN_W-1:0]   in_red,
  input  wire logic [rcmf_pkg::CHAN_W-1:0]   in_green,
  input  wire logic [rcmf_pkg::CHAN_W-1:0]   in_blue,
  input  wire logic [rcmf_pkg::CHAN_W-1:0]   in_alpha,
  // pixel out
  output      logic                          done,
  output      logic [rcmf_pkg::CHAN_W-1:0]   out_red,
  output      logic [rcmf_pkg::CHAN_W-1:0]   out_green,
  output      logic [rcmf_pkg::CHAN_W-1:0]   out_blue,
  output      logic [rcmf_pkg::CHAN_W-1:0]   out_alpha
);
  import rcmf_pkg::*;

  localparam int DEPTH = 4;  // register stages in a row

  coef_bank_t               coef;
  pix_col_t                 pix;
  logic [CHAN_W-1:0]        chan [NUM_CHAN];
  logic [DEPTH-1:0]         vld;   // valid bit riding along each stage
  logic                     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // fifth column is the constant 255 that scales the offset
  assign pix[0] = in_red;
  assign pix[1] = in_green;
  assign pix[2] = in_blue;
  assign pix[3] = in_alpha;
  assign pix[4] = CHAN_MAX;

  rcmf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // one pipeline per output channel; row m uses coefficients 5m..5m+4
  for (genvar m = 0; m < NUM_CHAN; m++) begin : g_row
    coef_row_t row_coef;

    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      assign row_coef[c] = coef_at(coef, 5'(m * NUM_COLS + c));
    end

    rcmf_row #(
      .FRAC_BITS (COEF_FRAC_BITS)
    ) u_row (
      .clk  (clk),
      .coef (row_coef),
      .pix  (pix),
      .chan (chan[m])
    );
  end

  // valid shift line, in step with the datapath stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], accept};
    end
  end

  assign done      = vld[DEPTH-1];
  assign out_red   = chan[0];
  assign out_green = chan[1];
  assign out_blue  = chan[2];
  assign out_alpha = chan[3];

  // every accepted pixel is followed by its done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("accepted pixel did not complete after 4 cycles");

  // no result without a matching accept
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    !accept ##1 !vld[0] ##1 !vld[1] ##1 !vld[2] |=> !done)
    else $error("result strobe with no pixel in flight");

  // coefficients only move on a completed APB write
  a_coef_hold: assert property (@(posedge clk) disable iff (rst)
    !(psel && penable && pwrite) |=> $stable(coef))
    else $error("coefficient register changed without a write");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the RGBA color matrix filter. Coefficient sets are
// loaded over APB while the pipe is empty. Pixels go in with random gaps, and
// each output word is checked against a scoreboard that recomputes the 4x5
// matrix product with its own copy of the coefficient bank.
// ============================================================================

module tb;
  import rcmf_pkg::*;

  localparam int FRAC_BITS       = 12;
  localparam int PIPE_LATENCY    = 4;                 // accept edge to result edge
  localparam int SETTLE_CYCLES   = PIPE_LATENCY + 4;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 10;
  localparam int WORDS_PER_PHASE = 115;
  localparam int IDLE_PERCENT    = 14;
  localparam int NOIDLE_PHASE    = 3;                 // long burst with no gaps
  localparam int LANES           = REG_W / COEF_W;    // coefficients per register
  localparam int NUM_COEFS       = NUM_CHAN * NUM_COLS;
  localparam int NARROW_SPAN     = 'hC00;             // +/-0.75 in Q3.12

  localparam logic [COEF_W-1:0] Q_ONE     = COEF_W'(1 << FRAC_BITS);
  localparam logic [COEF_W-1:0] Q_TWO     = COEF_W'(2 << FRAC_BITS);
  localparam logic [COEF_W-1:0] Q_MAX     = 16'h7FFF;
  localparam logic [COEF_W-1:0] Q_MIN     = 16'h8000;
  localparam logic [COEF_W-1:0] Q_NEG_LSB = 16'hFFFF;  // -1/4096

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  // coefficient i sits at element i; register k is elements 4k+3..4k
  typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_mat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the coefficient bank, predicts each pixel word and
  // checks output words in order.
  // --------------------------------------------------------------------------
  class color_matrix_scoreboard;
    logic [REG_W-1:0] coef_bank [NUM_GROUPS];
    rgba_t            expected_q [$];
    int               errors;

    function new();
      for (int i = 0; i < NUM_GROUPS; i++) coef_bank[i] = '0;
      errors = 0;
    endfunction

    // writes beyond the last register are dropped by the block
    function void set_coef(int sel, logic [REG_W-1:0] value);
      if (sel < NUM_GROUPS) coef_bank[sel] = value;
    endfunction

    function rgba_t apply_matrix(rgba_t px);
      longint            chan [NUM_COLS];
      longint            acc;
      longint            whole;
      logic [COEF_W-1:0] raw;
      logic [CHAN_W-1:0] res [NUM_CHAN];
      int                idx;
      chan[0] = px.red;
      chan[1] = px.green;
      chan[2] = px.blue;
      chan[3] = px.alpha;
      chan[4] = CHAN_MAX;
      for (int row = 0; row < NUM_CHAN; row++) begin
        acc = 0;
        for (int col = 0; col < NUM_COLS; col++) begin
          idx = row * NUM_COLS + col;
          raw = coef_bank[idx / LANES][(idx % LANES) * COEF_W +: COEF_W];
          acc += longint'($signed(raw)) * chan[col];
        end
        // negative sums (fractions too) go to 0, else truncate and saturate
        if (acc < 0) begin
          res[row] = '0;
        end else begin
          whole = acc >>> FRAC_BITS;
          res[row] = (whole > CHAN_MAX) ? CHAN_MAX : whole[CHAN_W-1:0];
        end
      end
      return '{red: res[0], green: res[1], blue: res[2], alpha: res[3]};
    endfunction

    function void note_pixel(rgba_t px);
      expected_q.push_back(apply_matrix(px));
    endfunction

    function void compare_chan(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rgba_t got);
      rgba_t want;
      if (expected_q.size() == 0) begin
        $error("output word %h with no pixel in flight", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_chan("out_red", want.red, got.red);
      compare_chan("out_green", want.green, got.green);
      compare_chan("out_blue", want.blue, got.blue);
      compare_chan("out_alpha", want.alpha, got.alpha);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_leftover();
      if (expected_q.size() != 0) begin
        $error("%0d output words never arrived", expected_q.size());
        errors += expected_q.size();
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [REG_W-1:0]  pwdata;
  logic [REG_W-1:0]  prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_blue;
  logic [CHAN_W-1:0] in_alpha;
  logic              done;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;

  color_matrix_scoreboard sb;
  int                     cycle_count;

  rgba_color_matrix_filter #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .in_alpha(in_alpha),
    .done(done),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_alpha(out_alpha)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung pipe or lost handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Output monitor. done is a one-cycle strobe that cannot be held off, so
  // every strobe is taken at the edge that closes its cycle.
  always @(posedge clk) begin
    if (rst === 1'b0 && done === 1'b1)
      sb.check_result({out_red, out_green, out_blue, out_alpha});
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task is entered just after a rising edge and returns just
  // after one, so each drive lands in a fresh time step.
  // --------------------------------------------------------------------------

  // APB write: setup cycle, access cycle, then an idle cycle so that back
  // to back writes never lower and raise psel in the same step.
  task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(sel) << (ADDR_W - REG_SEL_W);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_coef(sel, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(input coef_mat_t m);
    for (int k = 0; k < NUM_GROUPS; k++)
      write_reg(REG_SEL_W'(k), m[k * LANES +: LANES]);
  endtask

  // Holds the word until the edge that takes it; start stays high so the
  // next word can follow with no bubble.
  task automatic send_pixel(input rgba_t px);
    start    <= 1'b1;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    in_alpha <= px.alpha;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_pixel(px);
  endtask

  // Stop sending and wait until the pipe has drained.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic rgba_t random_pixel();
    logic [CHAN_W-1:0] ch [NUM_CHAN];
    for (int i = 0; i < NUM_CHAN; i++) begin
      case ($urandom_range(7))
        0:       ch[i] = '0;
        1:       ch[i] = '1;
        default: ch[i] = CHAN_W'($urandom);
      endcase
    end
    return '{red: ch[0], green: ch[1], blue: ch[2], alpha: ch[3]};
  endfunction

  // Each cycle idles with IDLE_PERCENT odds; runs of idle cycles give gaps
  // that land on every stage of the four-deep pipe.
  task automatic send_random(input int count, input bit with_idle);
    for (int i = 0; i < count; i++) begin
      while (with_idle && $urandom_range(99) < IDLE_PERCENT) begin
        start <= 1'b0;
        @(posedge clk);
      end
      send_pixel(random_pixel());
    end
  endtask

  function automatic coef_mat_t diag_matrix(logic [COEF_W-1:0] gain, logic [COEF_W-1:0] offset);
    coef_mat_t m;
    m = '0;
    for (int row = 0; row < NUM_CHAN; row++) begin
      m[row * NUM_COLS + row]          = gain;
      m[row * NUM_COLS + NUM_COLS - 1] = offset;
    end
    return m;
  endfunction

  function automatic coef_mat_t fill_matrix(logic [COEF_W-1:0] value);
    coef_mat_t m;
    for (int i = 0; i < NUM_COEFS; i++) m[i] = value;
    return m;
  endfunction

  // narrow sets keep most sums inside 0..255; full sets mostly clamp
  function automatic coef_mat_t random_matrix(bit narrow);
    coef_mat_t m;
    for (int i = 0; i < NUM_COEFS; i++)
      m[i] = narrow ? COEF_W'($urandom_range(2 * NARROW_SPAN) - NARROW_SPAN)
                    : COEF_W'($urandom);
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb       = new();
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    start    <= 1'b0;
    in_red   <= '0;
    in_green <= '0;
    in_blue  <= '0;
    in_alpha <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // coefficients come out of reset as zero: every channel reads 0
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h5A3C96E1);
    settle();

    // identity, extremes and alternating bit patterns pass straight through
    load_matrix(diag_matrix(Q_ONE, '0));
    send_pixel(32'h00000000);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'hAA55AA55);
    send_pixel(32'h55AA55AA);
    send_pixel(32'h01807FFE);
    settle();

    // writes past the last register must leave the bank alone
    for (int k = NUM_GROUPS; k < (1 << REG_SEL_W); k++)
      write_reg(REG_SEL_W'(k), '1);
    send_pixel(32'h12345678);
    settle();

    // gain 2.0: 127 -> 254, 128 -> exactly 256 -> saturates
    load_matrix(diag_matrix(Q_TWO, '0));
    send_pixel(32'h7F807F80);
    send_pixel(32'h00FF8001);
    settle();

    // gain 1.0 with offset -1/4096: truncation gives x-1, and 0 goes
    // slightly negative which must clamp to 0
    load_matrix(diag_matrix(Q_ONE, Q_NEG_LSB));
    send_pixel(32'h0001FF80);
    send_pixel(32'h00000000);
    send_pixel(32'h02FE0100);
    settle();

    // offset column alone: 1.0 * 255
    load_matrix(diag_matrix('0, Q_ONE));
    send_pixel(32'h00000000);
    settle();

    // extreme coefficient values everywhere
    load_matrix(fill_matrix(Q_MAX));
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h00000000);
    settle();
    load_matrix(fill_matrix(Q_MIN));
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h00000000);
    settle();
    load_matrix(fill_matrix(Q_NEG_LSB));
    send_pixel(32'h00000000);
    send_pixel(32'hFFFFFFFF);
    settle();

    // random coefficient sets, each followed by a random pixel stream
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_matrix(random_matrix(p % 3 != 0));
      if (p == RANDOM_PHASES / 2) begin
        // sender holds off mid-stream until the pipe is empty
        send_random(WORDS_PER_PHASE / 2, 1'b1);
        settle();
        send_random(WORDS_PER_PHASE - WORDS_PER_PHASE / 2, 1'b1);
      end else begin
        send_random(WORDS_PER_PHASE, p != NOIDLE_PHASE);
      end
      settle();
    end

    sb.flag_leftover();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
